@@ rtl/core/pcrct_pkg.sv @@
// Shared widths, defaults and the cell control type of the run change tracker.
`timescale 1ns / 1ps
`default_nettype none
package pcrct_pkg;

	// Field widths fixed by the channel key and sample format.
	localparam int KEY_W   = 16;
	localparam int DTYPE_W = 4;
	localparam int DID_W   = 8;
	localparam int MTYPE_W = 4;
	localparam int TS_W    = 63;
	localparam int VAL_W   = 64;

	// Default number of channel slots in the cell chain.
	localparam int DEF_TABLE_SLOTS = 64;

	// Result kind codes.
	localparam logic KIND_RUN    = 1'b0;
	localparam logic KIND_REFUSE = 1'b1;

	// Request op codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLOSE  = 1'b1;

	// Per-cell control: load writes the new run, shift takes the neighbor's run.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/per_channel_run_change_tracker_top.sv @@
// Top level of the per-channel run change tracker: control, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none
// A sample request is first captured; then every cell compares its key at once and
// the hit or free cell is updated; its result, if any, shows on the next cycle. A
// close-all request shifts the chain one run toward cell zero per cycle while runs
// are open, and cell zero is emitted. Slots fill from the lowest number and are
// freed only by close-all, so a fill count marks the valid cells. Results appear for
// exactly one cycle with result_valid high and cannot be held off by the receiver;
// last marks the final one.
module per_channel_run_change_tracker_top #(
	parameter int TABLE_SLOTS = pcrct_pkg::DEF_TABLE_SLOTS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire                                  op,
	input  wire  [pcrct_pkg::DTYPE_W-1:0]        device_type,
	input  wire  [pcrct_pkg::DID_W-1:0]          device_id,
	input  wire  [pcrct_pkg::MTYPE_W-1:0]        monitor_type,
	input  wire  [pcrct_pkg::TS_W-1:0]           time_stamp,
	input  wire  signed [pcrct_pkg::VAL_W-1:0]   sample_value,
	output logic                                 result_valid,
	output logic                                 kind,
	output logic [pcrct_pkg::DTYPE_W-1:0]        run_device_type,
	output logic [pcrct_pkg::DID_W-1:0]          run_device_id,
	output logic [pcrct_pkg::MTYPE_W-1:0]        run_monitor_type,
	output logic [pcrct_pkg::TS_W-1:0]           run_start,
	output logic [pcrct_pkg::TS_W-1:0]           run_end,
	output logic signed [pcrct_pkg::VAL_W-1:0]   run_value,
	output logic                                 last
);
	import pcrct_pkg::*;

	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SLOTS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_CLOSE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] key_q;
	logic [TS_W-1:0]  ts_q;
	logic [VAL_W-1:0] val_q;

	logic [KEY_W-1:0] c_key   [TABLE_SLOTS];
	logic [TS_W-1:0]  c_start [TABLE_SLOTS];
	logic [VAL_W-1:0] c_value [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] c_match;
	logic [TABLE_SLOTS-1:0] hit;
	cell_ctl_t        c_ctl   [TABLE_SLOTS];

	logic             any_hit;
	logic [TS_W-1:0]  hit_start;
	logic [VAL_W-1:0] hit_value;
	logic             changed;
	logic             full;
	logic             accept;
	logic             look;
	logic             closing;

	logic             res_valid_q;
	logic             res_kind_q;
	logic [KEY_W-1:0] res_key_q;
	logic [TS_W-1:0]  res_start_q;
	logic [TS_W-1:0]  res_end_q;
	logic [VAL_W-1:0] res_value_q;
	logic             res_last_q;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign look    = (state_q == ST_LOOK);
	assign closing = (state_q == ST_CLOSE);
	assign full    = (cnt_q == CNT_FULL);

	// Capture of the accepted request.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {device_type, device_id, monitor_type};
			ts_q  <= time_stamp;
			val_q <= sample_value;
		end
	end

	// Chain of slot cells; each shifts toward cell zero during close-all.
	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		logic [KEY_W-1:0] nb_key;
		logic [TS_W-1:0]  nb_start;
		logic [VAL_W-1:0] nb_value;

		if (i == TABLE_SLOTS - 1) begin : g_tail
			assign nb_key   = '0;
			assign nb_start = '0;
			assign nb_value = '0;
		end else begin : g_link
			assign nb_key   = c_key[i+1];
			assign nb_start = c_start[i+1];
			assign nb_value = c_value[i+1];
		end

		assign hit[i] = c_match[i] && (CNT_W'(i) < cnt_q);

		// A hit cell takes the new run on a change; the first free cell takes a new channel.
		assign c_ctl[i].load  = look && ((hit[i] && changed) ||
			(!any_hit && !full && (cnt_q == CNT_W'(i))));
		assign c_ctl[i].shift = closing;

		pcrct_cell u_cell (
			.clk       (clk),
			.ctl       (c_ctl[i]),
			.cmp_key   (key_q),
			.new_start (ts_q),
			.new_value (val_q),
			.nb_key    (nb_key),
			.nb_start  (nb_start),
			.nb_value  (nb_value),
			.key       (c_key[i]),
			.start     (c_start[i]),
			.value     (c_value[i]),
			.match     (c_match[i])
		);
	end

	// Read of the hit cell; keys are unique among valid cells, so at most one is selected.
	always_comb begin
		hit_start = '0;
		hit_value = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (hit[i]) begin
				hit_start = hit_start | c_start[i];
				hit_value = hit_value | c_value[i];
			end
		end
	end

	assign any_hit = |hit;
	assign changed = (hit_value != val_q);

	// Control state and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_CLOSE) begin
							state_q <= (cnt_q == '0) ? ST_IDLE : ST_CLOSE;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
					if (!any_hit && !full) begin
						cnt_q <= cnt_q + CNT_ONE;
					end
				end
				ST_CLOSE: begin
					cnt_q <= cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= closing || (look && ((any_hit && changed) || (!any_hit && full)));
		end
	end

	// Result payload; outside a lookup or a close-all it is loaded but never strobed.
	always_ff @(posedge clk) begin
		priority if (closing) begin
			res_kind_q  <= KIND_RUN;
			res_key_q   <= c_key[0];
			res_start_q <= c_start[0];
			res_end_q   <= ts_q;
			res_value_q <= c_value[0];
			res_last_q  <= (cnt_q == CNT_ONE);
		end else if (look && any_hit) begin
			res_kind_q  <= KIND_RUN;
			res_key_q   <= key_q;
			res_start_q <= hit_start;
			res_end_q   <= ts_q;
			res_value_q <= hit_value;
			res_last_q  <= 1'b1;
		end else begin
			res_kind_q  <= KIND_REFUSE;
			res_key_q   <= key_q;
			res_start_q <= ts_q;
			res_end_q   <= ts_q;
			res_value_q <= val_q;
			res_last_q  <= 1'b1;
		end
	end

	assign result_valid     = res_valid_q;
	assign kind             = res_kind_q;
	assign run_device_type  = res_key_q[KEY_W-1 -: DTYPE_W];
	assign run_device_id    = res_key_q[MTYPE_W +: DID_W];
	assign run_monitor_type = res_key_q[MTYPE_W-1:0];
	assign run_start        = res_start_q;
	assign run_end          = res_end_q;
	assign run_value        = res_value_q;
	assign last             = res_last_q;

`ifndef SYNTHESIS
	// The fill count never passes the number of cells.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("fill count exceeds the number of slots");

	// At most one valid cell holds the looked-up key.
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		look |-> $onehot0(hit))
		else $error("channel key found in more than one slot");

	// A refused sample produces a single, final result.
	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_REFUSE) |-> last)
		else $error("refused sample result not marked last");

	// The final run of a close-all leaves the table empty.
	a_close_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(closing && cnt_q == CNT_ONE) |=> (cnt_q == '0 && !busy))
		else $error("table not empty after close-all");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pcrct_cell.sv @@
// One channel slot of the chain: holds a run and compares its key.
`timescale 1ns / 1ps
`default_nettype none
module pcrct_cell (
	input  wire                            clk,
	input  wire  pcrct_pkg::cell_ctl_t     ctl,
	input  wire  [pcrct_pkg::KEY_W-1:0]    cmp_key,
	input  wire  [pcrct_pkg::TS_W-1:0]     new_start,
	input  wire  [pcrct_pkg::VAL_W-1:0]    new_value,
	input  wire  [pcrct_pkg::KEY_W-1:0]    nb_key,
	input  wire  [pcrct_pkg::TS_W-1:0]     nb_start,
	input  wire  [pcrct_pkg::VAL_W-1:0]    nb_value,
	output logic [pcrct_pkg::KEY_W-1:0]    key,
	output logic [pcrct_pkg::TS_W-1:0]     start,
	output logic [pcrct_pkg::VAL_W-1:0]    value,
	output logic                           match
);
	import pcrct_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [TS_W-1:0]  start_q;
	logic [VAL_W-1:0] value_q;

	// Run storage: a load writes the request's run, a shift takes the neighbor's.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= cmp_key;
			start_q <= new_start;
			value_q <= new_value;
		end else if (ctl.shift) begin
			key_q   <= nb_key;
			start_q <= nb_start;
			value_q <= nb_value;
		end
	end

	assign key   = key_q;
	assign start = start_q;
	assign value = value_q;
	assign match = (key_q == cmp_key);

endmodule
`default_nettype wire

@@ bench/tb_per_channel_run_change_tracker_top.sv @@
// Self-checking testbench for the per-channel run change tracker top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_per_channel_run_change_tracker_top;
	import pcrct_pkg::*;

	localparam int SLOTS        = DEF_TABLE_SLOTS;
	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 16;

	localparam logic [VAL_W-1:0] VMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] VMIN  = 64'h8000_0000_0000_0000;
	localparam logic [VAL_W-1:0] VNEG1 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [TS_W-1:0]  TSMAX = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [TS_W-1:0]  TS_HI = 63'h5555_5555_5555_5555;
	localparam logic [TS_W-1:0]  TS_LO = 63'h2AAA_AAAA_AAAA_AAAA;

	// One request as driven onto the ports.
	typedef struct packed {
		logic               op;
		logic [DTYPE_W-1:0] dev_type;
		logic [DID_W-1:0]   dev_id;
		logic [MTYPE_W-1:0] mon_type;
		logic [TS_W-1:0]    ts;
		logic [VAL_W-1:0]   value;
	} request_t;

	// One finished run or refusal record as seen on the result ports.
	typedef struct packed {
		logic               kind;
		logic [DTYPE_W-1:0] dev_type;
		logic [DID_W-1:0]   dev_id;
		logic [MTYPE_W-1:0] mon_type;
		logic [TS_W-1:0]    t_begin;
		logic [TS_W-1:0]    t_end;
		logic [VAL_W-1:0]   value;
		logic               last;
	} run_rec_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      start        = 1'b0;
	logic                      op           = OP_SAMPLE;
	logic [DTYPE_W-1:0]        device_type  = '0;
	logic [DID_W-1:0]          device_id    = '0;
	logic [MTYPE_W-1:0]        monitor_type = '0;
	logic [TS_W-1:0]           time_stamp   = '0;
	logic signed [VAL_W-1:0]   sample_value = '0;
	logic                      busy;
	logic                      result_valid;
	logic                      kind;
	logic [DTYPE_W-1:0]        run_device_type;
	logic [DID_W-1:0]          run_device_id;
	logic [MTYPE_W-1:0]        run_monitor_type;
	logic [TS_W-1:0]           run_start;
	logic [TS_W-1:0]           run_end;
	logic signed [VAL_W-1:0]   run_value;
	logic                      last;

	// Shadow copy of the channel table.
	logic                slot_used [SLOTS];
	logic [KEY_W-1:0]    slot_chan [SLOTS];
	logic [TS_W-1:0]     slot_t0   [SLOTS];
	logic [VAL_W-1:0]    slot_val  [SLOTS];

	run_rec_t expected_runs [$];
	run_rec_t fresh_runs [$];

	// Directed stimulus table.
	request_t dir_req [$];
	int       dir_nlit [$];
	run_rec_t dir_lit [$];

	int          mismatches   = 0;
	int          n_requests   = 0;
	int          n_closes     = 0;
	int          n_runs_seen  = 0;
	int          n_refusals   = 0;
	int          cycle_count  = 0;
	bit          no_gaps      = 1'b0;
	logic [TS_W-1:0] t_now    = '0;

	per_channel_run_change_tracker_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.op               (op),
		.device_type      (device_type),
		.device_id        (device_id),
		.monitor_type     (monitor_type),
		.time_stamp       (time_stamp),
		.sample_value     (sample_value),
		.result_valid     (result_valid),
		.kind             (kind),
		.run_device_type  (run_device_type),
		.run_device_id    (run_device_id),
		.run_monitor_type (run_monitor_type),
		.run_start        (run_start),
		.run_end          (run_end),
		.run_value        (run_value),
		.last             (last)
	);

	// Free-running clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due.", cycle_count,
				expected_runs.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [TS_W-1:0] rand_ts();
		return TS_W'({$urandom, $urandom});
	endfunction

	function automatic logic [VAL_W-1:0] rand_val();
		return {$urandom, $urandom};
	endfunction

	// Values lean toward the extremes so that equal values recur often.
	function automatic logic [VAL_W-1:0] pick_value();
		unique case ($urandom_range(0, 7))
			0: begin
				return VMIN;
			end
			1: begin
				return VMAX;
			end
			2: begin
				return VNEG1;
			end
			3: begin
				return '0;
			end
			default: begin
				return rand_val();
			end
		endcase
	endfunction

	// Mostly rising times, with an occasional jump anywhere.
	function automatic logic [TS_W-1:0] next_ts();
		if ($urandom_range(0, 15) == 0)
			t_now = rand_ts();
		else
			t_now = t_now + $urandom_range(0, 500);
		return t_now;
	endfunction

	function automatic request_t mk_req(input logic rop, input logic [KEY_W-1:0] chan,
			input logic [TS_W-1:0] ts, input logic [VAL_W-1:0] value);
		request_t r;
		r.op = rop;
		{r.dev_type, r.dev_id, r.mon_type} = chan;
		r.ts = ts;
		r.value = value;
		return r;
	endfunction

	function automatic run_rec_t mk_rec(input logic rkind, input logic [KEY_W-1:0] chan,
			input logic [TS_W-1:0] t_begin, input logic [TS_W-1:0] t_end,
			input logic [VAL_W-1:0] value, input logic rlast);
		run_rec_t rec;
		rec.kind = rkind;
		{rec.dev_type, rec.dev_id, rec.mon_type} = chan;
		rec.t_begin = t_begin;
		rec.t_end = t_end;
		rec.value = value;
		rec.last = rlast;
		return rec;
	endfunction

	function automatic string fmt_run(input run_rec_t rec);
		return $sformatf("kind=%0d key=%h/%h/%h start=%h end=%h value=%0d last=%0d",
			rec.kind, rec.dev_type, rec.dev_id, rec.mon_type, rec.t_begin, rec.t_end,
			$signed(rec.value), rec.last);
	endfunction

	// Predict the records one request produces and update the shadow table.
	function automatic void predict_runs(input request_t r);
		logic [KEY_W-1:0] chan;
		int hit;
		int free_slot;
		run_rec_t rec;
		chan = {r.dev_type, r.dev_id, r.mon_type};
		hit = -1;
		free_slot = -1;
		fresh_runs.delete();
		if (r.op == OP_CLOSE) begin
			// Flush every open run in slot order, last flag on the final one.
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i]) begin
					fresh_runs.push_back(mk_rec(KIND_RUN, slot_chan[i], slot_t0[i], r.ts,
						slot_val[i], 1'b0));
					slot_used[i] = 1'b0;
				end
			end
			if (fresh_runs.size() > 0) begin
				rec = fresh_runs.pop_back();
				rec.last = 1'b1;
				fresh_runs.push_back(rec);
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i]) begin
					if (hit < 0 && slot_chan[i] == chan)
						hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit < 0 && free_slot < 0) begin
				// Table full: refuse and echo the sample.
				fresh_runs.push_back(mk_rec(KIND_REFUSE, chan, r.ts, r.ts, r.value, 1'b1));
			end else if (hit < 0) begin
				slot_used[free_slot] = 1'b1;
				slot_chan[free_slot] = chan;
				slot_t0[free_slot] = r.ts;
				slot_val[free_slot] = r.value;
			end else if (slot_val[hit] != r.value) begin
				fresh_runs.push_back(mk_rec(KIND_RUN, chan, slot_t0[hit], r.ts, slot_val[hit],
					1'b1));
				slot_t0[hit] = r.ts;
				slot_val[hit] = r.value;
			end
		end
	endfunction

	// Hand one request over, then queue what it should produce. With n_lit of zero or
	// one the typed-in expectation replaces the predicted one.
	task automatic send(input request_t r, input int n_lit, input run_rec_t lit);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= r.op;
		device_type <= r.dev_type;
		device_id <= r.dev_id;
		monitor_type <= r.mon_type;
		time_stamp <= r.ts;
		sample_value <= r.value;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_requests++;
		if (r.op == OP_CLOSE)
			n_closes++;
		predict_runs(r);
		if (n_lit < 0) begin
			foreach (fresh_runs[i])
				expected_runs.push_back(fresh_runs[i]);
		end else if (n_lit == 1) begin
			expected_runs.push_back(lit);
		end
	endtask

	// Hold off new requests until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_runs.size() != 0) @(posedge clk);
	endtask

	function automatic void row(input logic rop, input logic [DTYPE_W-1:0] dt,
			input logic [DID_W-1:0] di, input logic [MTYPE_W-1:0] mt,
			input logic [TS_W-1:0] ts, input logic [VAL_W-1:0] value, input int n_lit,
			input logic [TS_W-1:0] lit_begin, input logic [TS_W-1:0] lit_end,
			input logic [VAL_W-1:0] lit_value);
		dir_req.push_back(mk_req(rop, {dt, di, mt}, ts, value));
		dir_nlit.push_back(n_lit);
		dir_lit.push_back(mk_rec(KIND_RUN, {dt, di, mt}, lit_begin, lit_end, lit_value, 1'b1));
	endfunction

	// Open 64 neighboring channels, then poke at the full table and flush it.
	task automatic fill_table();
		logic [DTYPE_W-1:0] dt;
		logic [DID_W-1:0]   base;
		logic [MTYPE_W-1:0] mt;
		int idx;
		drain();
		send(mk_req(OP_CLOSE, KEY_W'($urandom), next_ts(), rand_val()), -1, '0);
		dt = DTYPE_W'($urandom);
		base = DID_W'($urandom);
		mt = MTYPE_W'($urandom);
		for (int i = 0; i < SLOTS; i++)
			send(mk_req(OP_SAMPLE, {dt, base + DID_W'(i), mt}, next_ts(), pick_value()), -1,
				'0);
		for (int j = 0; j < 10; j++) begin
			if ($urandom_range(0, 1) == 0) begin
				// Unseen channel: refused.
				send(mk_req(OP_SAMPLE, {dt, base + DID_W'($urandom_range(SLOTS, 255)), mt},
					next_ts(), rand_val()), -1, '0);
			end else begin
				// Known channel: slot index equals the offset since the table filled from empty.
				idx = $urandom_range(0, SLOTS - 1);
				send(mk_req(OP_SAMPLE, {dt, base + DID_W'(idx), mt}, next_ts(),
					($urandom_range(0, 1) == 0) ? slot_val[idx] : pick_value()), -1, '0);
			end
		end
		send(mk_req(OP_CLOSE, KEY_W'($urandom), next_ts(), rand_val()), -1, '0);
	endtask

	// A few channels with a small set of values, closed at the end.
	task automatic run_episode();
		logic [KEY_W-1:0] pool [8];
		logic [VAL_W-1:0] vals [3];
		int n_chan;
		int len;
		request_t r;
		n_chan = $urandom_range(1, 8);
		len = $urandom_range(5, 20);
		for (int i = 0; i < 8; i++)
			pool[i] = KEY_W'($urandom);
		for (int k = 0; k < 3; k++)
			vals[k] = pick_value();
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(0, 15) == 0)
				r = mk_req(OP_CLOSE, KEY_W'($urandom), next_ts(), rand_val());
			else
				r = mk_req(OP_SAMPLE, pool[$urandom_range(0, n_chan - 1)], next_ts(),
					($urandom_range(0, 3) == 0) ? rand_val() : vals[$urandom_range(0, 2)]);
			send(r, -1, '0);
		end
		if ($urandom_range(0, 2) == 0)
			drain();
		send(mk_req(OP_CLOSE, KEY_W'($urandom), next_ts(), rand_val()), -1, '0);
	endtask

	// Compare each result against the oldest expectation.
	always @(posedge clk) begin : check_results
		run_rec_t got;
		run_rec_t want;
		if (arst_n && result_valid) begin
			got = '{kind, run_device_type, run_device_id, run_monitor_type, run_start,
				run_end, run_value, last};
			if (got.kind == KIND_REFUSE)
				n_refusals++;
			else
				n_runs_seen++;
			if (expected_runs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result at cycle %0d: %s", cycle_count, fmt_run(got));
			end else begin
				want = expected_runs.pop_front();
				if (got.kind !== want.kind || got.dev_type !== want.dev_type
						|| got.dev_id !== want.dev_id || got.mon_type !== want.mon_type
						|| got.t_begin !== want.t_begin || got.t_end !== want.t_end
						|| got.value !== want.value || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at cycle %0d", cycle_count);
						$display("  expected %s", fmt_run(want));
						$display("  actual   %s", fmt_run(got));
					end
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int n_directed;
		int ep;
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;

		// Directed rows: empty flush, opening, same value, changes at the extremes,
		// time running backward, a sign-only change, and a flush of one run.
		row(OP_CLOSE,  4'h0, 8'h00, 4'h0, 63'd0,  '0,    0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd0,  '0,    0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd5,  '0,    0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd9,  VMAX,  1, 63'd0, 63'd9, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd3,  VMIN,  1, 63'd9, 63'd3, VMAX);
		row(OP_SAMPLE, 4'hF, 8'hFF, 4'hF, TSMAX,  VNEG1, 0, '0, '0, '0);
		row(OP_SAMPLE, 4'hF, 8'hFF, 4'hF, 63'd0,  VMIN,  1, TSMAX, 63'd0, VNEG1);
		row(OP_SAMPLE, 4'hF, 8'h00, 4'h0, 63'd100, 64'd1, 0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'hFF, 4'h0, 63'd101, 64'd2, 0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'hF, 63'd102, 64'd2, 0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd200, VMIN, 0, '0, '0, '0);
		row(OP_CLOSE,  4'h0, 8'h00, 4'h0, TSMAX,  '0,   -1, '0, '0, '0);
		row(OP_CLOSE,  4'h0, 8'h00, 4'h0, 63'd0,  '0,    0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd7,  '0,    0, '0, '0, '0);
		row(OP_SAMPLE, 4'h0, 8'h00, 4'h0, 63'd8,  VMIN,  1, 63'd7, 63'd8, '0);
		row(OP_SAMPLE, 4'hF, 8'h00, 4'h0, 63'd9,  64'd6, 0, '0, '0, '0);
		row(OP_CLOSE,  4'h0, 8'h00, 4'h0, 63'd1,  '0,   -1, '0, '0, '0);
		row(OP_SAMPLE, 4'h5, 8'hA5, 4'hA, TS_HI,  64'h5555_5555_5555_5555, 0, '0, '0, '0);
		row(OP_SAMPLE, 4'h5, 8'hA5, 4'hA, TS_LO,  64'hAAAA_AAAA_AAAA_AAAA, 1, TS_HI, TS_LO,
			64'h5555_5555_5555_5555);
		row(OP_CLOSE,  4'h5, 8'hA5, 4'hA, TS_LO,  '0,    1, TS_LO, TS_LO,
			64'hAAAA_AAAA_AAAA_AAAA);
		n_directed = dir_req.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_req[i])
			send(dir_req[i], dir_nlit[i], dir_lit[i]);

		// Random part: small episodes, one of them filling the table to the brim.
		ep = 0;
		while (n_requests < n_directed + RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (ep == 2)
				fill_table();
			else
				run_episode();
			ep++;
		end

		start <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d requests (%0d directed, %0d close-all) over %0d cycles.",
			n_requests, n_directed, n_closes, cycle_count);
		$display("Checked %0d run records and %0d refusals, %0d mismatches.",
			n_runs_seen, n_refusals, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/pcrct_pkg.sv
rtl/core/pcrct_cell.sv
rtl/core/per_channel_run_change_tracker_top.sv
bench/tb_per_channel_run_change_tracker_top.sv
